// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the forward-kinematics RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define FK_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FK_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fk_pkg.sv -----
// Shared types, constants and arithmetic helpers for the arm forward kinematics.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fk_pkg;

    localparam int NJ    = 6;
    localparam int ANG_W = 26;
    localparam int LEN_W = 26;
    localparam int POS_W = 27;
    localparam int ROT_W = 32;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 376;

    localparam logic [24:0] FULL_TURN    = 25'd23592960;
    localparam logic [24:0] QUARTER_TURN = 25'd5898240;
    localparam logic [24:0] EIGHTH_TURN  = 25'd2949120;

    // pi/180 scaled by 2^46, split so each partial product stays narrow.
    localparam logic [40:0] DEG2RAD_K  = 41'd1228166276394;
    localparam logic [20:0] DEG2RAD_HI = DEG2RAD_K[40:20];
    localparam logic [19:0] DEG2RAD_LO = DEG2RAD_K[19:0];

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic [25:0] LEN_MAX        = 26'd65536000;
    localparam logic signed [31:0] POS_MAX = 32'sd65536000;

    localparam logic [25:0] UPPER_RESET = 26'd22189703;
    localparam logic [25:0] FORE_RESET  = 26'd22107936;

    localparam logic [0:0] CFG_UPPER = 1'b0;
    localparam logic [0:0] CFG_FORE  = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    // Series divisors per term index, and floor(2^32 / d) for the reciprocal division.
    // The sine series has five terms; its sixth slot is computed but never added.
    localparam logic [7:0] SIN_DIV [0:5] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd132};
    localparam logic [7:0] COS_DIV [0:5] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
    localparam logic [31:0] SIN_RECIP [0:5] = '{
        32'(64'h1_0000_0000 / 64'd6),   32'(64'h1_0000_0000 / 64'd20),
        32'(64'h1_0000_0000 / 64'd42),  32'(64'h1_0000_0000 / 64'd72),
        32'(64'h1_0000_0000 / 64'd110), 32'(64'h1_0000_0000 / 64'd132)};
    localparam logic [31:0] COS_RECIP [0:5] = '{
        32'(64'h1_0000_0000 / 64'd2),   32'(64'h1_0000_0000 / 64'd12),
        32'(64'h1_0000_0000 / 64'd30),  32'(64'h1_0000_0000 / 64'd56),
        32'(64'h1_0000_0000 / 64'd90),  32'(64'h1_0000_0000 / 64'd132)};

    typedef logic signed [31:0] t_q30;

    // Sine and cosine of all six joints, joint 1 in the lowest slot.
    typedef struct packed {
        logic [NJ-1:0][31:0] sn;
        logic [NJ-1:0][31:0] cs;
    } t_trig;

    // Shift right by 30, rounding to nearest with ties away from zero.
    function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = v[63] ? 64'(-v) : 64'(v);
        rnd = (mag + 64'd536870912) >> 30;
        round_q30 = v[63] ? -$signed(rnd) : $signed(rnd);
    endfunction

    function automatic t_q30 clamp_q30(input logic signed [63:0] v);
        if (v > 64'sd1073741824) begin
            clamp_q30 = ONE_Q30;
        end else if (v < -64'sd1073741824) begin
            clamp_q30 = -ONE_Q30;
        end else begin
            clamp_q30 = 32'(v);
        end
    endfunction

endpackage

// ----- hw/rtl/fk_front.sv -----
// Front end: holds one incoming set of joint angles and forms sine and cosine
// of all six joints in parallel lanes. Depends on fk_pkg.
`timescale 1ns / 1ps

module fk_front import fk_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [NJ-1:0][ANG_W-1:0]  i_angles,
    output logic                      o_push,
    output t_trig                     o_trig,
    input  logic                      i_full
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FOLD = 4'd1;
    localparam logic [3:0] ST_MULK = 4'd2;
    localparam logic [3:0] ST_X    = 4'd3;
    localparam logic [3:0] ST_SQ   = 4'd4;
    localparam logic [3:0] ST_X2   = 4'd5;
    localparam logic [3:0] ST_A    = 4'd6;
    localparam logic [3:0] ST_B    = 4'd7;
    localparam logic [3:0] ST_C    = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;
    localparam logic [3:0] ST_PUSH = 4'd10;

    localparam logic [2:0] K_LAST = 3'd5;
    localparam logic signed [26:0] FULL_S = 27'sd23592960;

    logic [3:0] r_state, n_state;
    logic [2:0] r_k;
    logic       r_hold_vld;
    logic [NJ-1:0][ANG_W-1:0] r_hold;
    logic       w_start;

    logic [24:0] r_red  [0:NJ-1];
    logic [1:0]  r_q    [0:NJ-1];
    logic [21:0] r_g    [0:NJ-1];
    logic        r_swap [0:NJ-1];
    logic [42:0] r_ph   [0:NJ-1];
    logic [41:0] r_pl   [0:NJ-1];
    logic [29:0] r_x    [0:NJ-1];
    logic [59:0] r_sq   [0:NJ-1];
    logic [29:0] r_x2   [0:NJ-1];
    logic [29:0] r_st   [0:NJ-1];
    logic [30:0] r_ct   [0:NJ-1];
    logic signed [31:0] r_ts [0:NJ-1];
    logic signed [31:0] r_tc [0:NJ-1];
    logic [59:0] r_ms   [0:NJ-1];
    logic [60:0] r_mc   [0:NJ-1];
    logic [29:0] r_vs   [0:NJ-1];
    logic [30:0] r_vc   [0:NJ-1];
    logic [61:0] r_qs   [0:NJ-1];
    logic [62:0] r_qc   [0:NJ-1];
    t_q30        r_sin  [0:NJ-1];
    t_q30        r_cos  [0:NJ-1];

    logic [24:0] c_red  [0:NJ-1];
    logic [1:0]  c_q    [0:NJ-1];
    logic [21:0] c_g    [0:NJ-1];
    logic        c_swap [0:NJ-1];
    logic [29:0] c_x    [0:NJ-1];
    logic [29:0] c_x2   [0:NJ-1];
    logic [29:0] c_snt  [0:NJ-1];
    logic [30:0] c_cst  [0:NJ-1];
    t_q30        c_sin  [0:NJ-1];
    t_q30        c_cos  [0:NJ-1];

    assign o_ready = !r_hold_vld;
    assign w_start = (r_state == ST_IDLE) && r_hold_vld;
    assign o_push  = (r_state == ST_PUSH) && !i_full;

    always_comb begin
        for (int l = 0; l < NJ; l++) begin
            o_trig.sn[l] = r_sin[l];
            o_trig.cs[l] = r_cos[l];
        end
    end

    // Per-lane arithmetic for each step of the sequence.
    always_comb begin
        logic signed [26:0] ang;
        logic signed [26:0] w;
        logic [24:0] base;
        logic [22:0] f;
        logic [63:0] xs;
        logic [60:0] x2s;
        logic [29:0] qs0;
        logic [30:0] qc0;
        logic [37:0] rs;
        logic [38:0] rc;
        logic signed [31:0] tsc;
        logic signed [31:0] tcc;
        logic signed [31:0] s0;
        logic signed [31:0] c0;
        for (int l = 0; l < NJ; l++) begin
            // Wrap the angle into one turn.
            ang = {r_hold[l][ANG_W-1], r_hold[l]};
            if (ang < 0) begin
                w = ang + FULL_S;
                if (w < 0) begin
                    w = w + FULL_S;
                end
            end else if (ang >= FULL_S) begin
                w = ang - FULL_S;
            end else begin
                w = ang;
            end
            c_red[l] = w[24:0];

            // Quadrant, then fold the upper half of the quadrant onto the lower.
            if (r_red[l] >= 25'(3 * QUARTER_TURN)) begin
                c_q[l] = 2'd3;
                base = 25'(3 * QUARTER_TURN);
            end else if (r_red[l] >= 25'(2 * QUARTER_TURN)) begin
                c_q[l] = 2'd2;
                base = 25'(2 * QUARTER_TURN);
            end else if (r_red[l] >= QUARTER_TURN) begin
                c_q[l] = 2'd1;
                base = QUARTER_TURN;
            end else begin
                c_q[l] = 2'd0;
                base = 25'd0;
            end
            f = 23'(r_red[l] - base);
            c_swap[l] = (25'(f) > EIGHTH_TURN);
            c_g[l] = c_swap[l] ? 22'(QUARTER_TURN - 25'(f)) : 22'(f);

            xs = (64'(r_ph[l]) << 20) + 64'(r_pl[l]) + 64'h8000_0000;
            c_x[l] = xs[61:32];
            x2s = 61'(r_sq[l]) + 61'd536870912;
            c_x2[l] = x2s[59:30];

            // Reciprocal quotient is low by at most one; one compare fixes it.
            qs0 = r_qs[l][61:32];
            qc0 = r_qc[l][62:32];
            rs = 38'(r_vs[l]) - 38'(qs0) * 38'(SIN_DIV[r_k]);
            rc = 39'(r_vc[l]) - 39'(qc0) * 39'(COS_DIV[r_k]);
            c_snt[l] = qs0 + 30'(rs >= 38'(SIN_DIV[r_k]));
            c_cst[l] = qc0 + 31'(rc >= 39'(COS_DIV[r_k]));

            tsc = (r_ts[l] < 0) ? 32'sd0 : ((r_ts[l] > ONE_Q30) ? ONE_Q30 : r_ts[l]);
            tcc = (r_tc[l] < 0) ? 32'sd0 : ((r_tc[l] > ONE_Q30) ? ONE_Q30 : r_tc[l]);
            s0 = r_swap[l] ? tcc : tsc;
            c0 = r_swap[l] ? tsc : tcc;
            case (r_q[l])
                2'd0: begin
                    c_sin[l] = s0;
                    c_cos[l] = c0;
                end
                2'd1: begin
                    c_sin[l] = c0;
                    c_cos[l] = -s0;
                end
                2'd2: begin
                    c_sin[l] = -s0;
                    c_cos[l] = -c0;
                end
                default: begin
                    c_sin[l] = -c0;
                    c_cos[l] = s0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (r_hold_vld) n_state = ST_FOLD;
            ST_FOLD: n_state = ST_MULK;
            ST_MULK: n_state = ST_X;
            ST_X:    n_state = ST_SQ;
            ST_SQ:   n_state = ST_X2;
            ST_X2:   n_state = ST_A;
            ST_A:    n_state = ST_B;
            ST_B:    n_state = ST_C;
            ST_C:    n_state = (r_k == K_LAST) ? ST_FIN : ST_A;
            ST_FIN:  n_state = ST_PUSH;
            ST_PUSH: if (!i_full) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_hold_vld <= 1'b0;
            r_k        <= 3'd0;
        end else begin
            r_state <= n_state;
            if (i_valid && o_ready) begin
                r_hold_vld <= 1'b1;
            end else if (w_start) begin
                r_hold_vld <= 1'b0;
            end
            if (r_state == ST_X2) begin
                r_k <= 3'd0;
            end else if (r_state == ST_C) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_hold <= i_angles;
        end
        for (int l = 0; l < NJ; l++) begin
            case (r_state)
                ST_IDLE: r_red[l] <= c_red[l];
                ST_FOLD: begin
                    r_q[l]    <= c_q[l];
                    r_g[l]    <= c_g[l];
                    r_swap[l] <= c_swap[l];
                end
                ST_MULK: begin
                    r_ph[l] <= r_g[l] * DEG2RAD_HI;
                    r_pl[l] <= r_g[l] * DEG2RAD_LO;
                end
                ST_X:  r_x[l] <= c_x[l];
                ST_SQ: r_sq[l] <= r_x[l] * r_x[l];
                ST_X2: begin
                    r_x2[l] <= c_x2[l];
                    r_st[l] <= r_x[l];
                    r_ts[l] <= $signed({2'b00, r_x[l]});
                    r_ct[l] <= 31'(ONE_Q30);
                    r_tc[l] <= ONE_Q30;
                end
                ST_A: begin
                    r_ms[l] <= r_st[l] * r_x2[l];
                    r_mc[l] <= r_ct[l] * r_x2[l];
                end
                ST_B: begin
                    r_vs[l] <= r_ms[l][59:30];
                    r_vc[l] <= r_mc[l][60:30];
                    r_qs[l] <= r_ms[l][59:30] * SIN_RECIP[r_k];
                    r_qc[l] <= r_mc[l][60:30] * COS_RECIP[r_k];
                end
                ST_C: begin
                    r_st[l] <= c_snt[l];
                    r_ct[l] <= c_cst[l];
                    // Terms alternate in sign, starting with a subtraction.
                    if (r_k != K_LAST) begin
                        r_ts[l] <= r_k[0] ? r_ts[l] + $signed({2'b00, c_snt[l]})
                                          : r_ts[l] - $signed({2'b00, c_snt[l]});
                    end
                    r_tc[l] <= r_k[0] ? r_tc[l] + $signed({1'b0, c_cst[l]})
                                      : r_tc[l] - $signed({1'b0, c_cst[l]});
                end
                ST_FIN: begin
                    r_sin[l] <= c_sin[l];
                    r_cos[l] <= c_cos[l];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/fk_queue.sv -----
// Two-entry queue of sine/cosine sets between the front and back ends.
// Depends on fk_pkg.
`timescale 1ns / 1ps

module fk_queue import fk_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_trig i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_trig o_data,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_trig            r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/fk_back.sv -----
// Back end: chains the link transforms with one three-product dot-product
// stage and holds the finished pose in the output register. Depends on fk_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fk_back import fk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_trig                 i_trig,
    output logic                  o_pop,
    input  logic [LEN_W-1:0]      i_upper_len,
    input  logic [LEN_W-1:0]      i_fore_len,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LP    = 3'd1;
    localparam logic [2:0] ST_LP2   = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_COPY  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // Links composed after the base link, in order.
    localparam logic [2:0] LNK_UPPER = 3'd0;
    localparam logic [2:0] LNK_FORE  = 3'd1;
    localparam logic [2:0] LNK_PERM  = 3'd2;
    localparam logic [2:0] LNK_ROLL  = 3'd3;
    localparam logic [2:0] LNK_PITCH = 3'd4;
    localparam logic [2:0] LNK_LAST  = 3'd5;

    localparam logic [1:0] COL_POS = 2'd3;

    logic [2:0] r_state;
    logic [2:0] r_m;
    logic [1:0] r_row, r_col;

    t_q30 r_s [0:NJ-1];
    t_q30 r_c [0:NJ-1];
    t_q30 r_t  [0:2][0:2];
    t_q30 r_tp [0:2];
    t_q30 r_nr [0:2][0:2];
    t_q30 r_np [0:2];
    t_q30 r_l  [0:2][0:2];
    t_q30 r_lp0, r_lp1;
    logic signed [63:0] r_lpc, r_lps;

    logic               r_pvld;
    logic [1:0]         r_prow, r_pcol;
    logic signed [63:0] r_prod [0:2];

    logic                  r_o_vld;
    logic [OUT_DATA_W-1:0] r_o_data;

    t_q30               c_l [0:2][0:2];
    logic signed [63:0] c_lc, c_ls;
    t_q30               c_b [0:2];
    logic signed [63:0] c_sum, c_rnd;
    logic               w_load;
    logic [OUT_DATA_W-1:0] c_out;

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;
    assign w_load  = (r_state == ST_OUT) && (!r_o_vld || i_ready);

    // Rotation part of the link being composed, and its length products.
    always_comb begin
        logic signed [63:0] lu, lf;
        lu = $signed({1'b0, i_upper_len});
        lf = $signed({1'b0, i_fore_len});
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                c_l[i][j] = '0;
            end
        end
        c_lc = '0;
        c_ls = '0;
        case (r_m)
            LNK_UPPER: begin
                c_l[0][0] = r_c[1];  c_l[0][1] = -r_s[1];
                c_l[1][0] = r_s[1];  c_l[1][1] = r_c[1];
                c_l[2][2] = ONE_Q30;
                c_lc = lu * r_c[1];
                c_ls = lu * r_s[1];
            end
            LNK_FORE: begin
                c_l[0][0] = r_c[2];  c_l[0][2] = -r_s[2];
                c_l[1][0] = r_s[2];  c_l[1][2] = r_c[2];
                c_l[2][1] = -ONE_Q30;
                c_lc = lf * r_c[2];
                c_ls = lf * r_s[2];
            end
            LNK_PERM: begin
                c_l[0][2] = ONE_Q30;
                c_l[1][0] = ONE_Q30;
                c_l[2][1] = ONE_Q30;
            end
            LNK_ROLL: begin
                c_l[0][0] = -r_s[3]; c_l[0][2] = r_c[3];
                c_l[1][0] = r_c[3];  c_l[1][2] = r_s[3];
                c_l[2][1] = ONE_Q30;
            end
            LNK_PITCH: begin
                c_l[0][0] = r_c[4];  c_l[0][2] = -r_s[4];
                c_l[1][0] = r_s[4];  c_l[1][2] = r_c[4];
                c_l[2][1] = -ONE_Q30;
            end
            default: begin
                c_l[0][0] = r_c[5];  c_l[0][1] = -r_s[5];
                c_l[1][0] = r_s[5];  c_l[1][1] = r_c[5];
                c_l[2][2] = ONE_Q30;
            end
        endcase
    end

    // Column of the link taken by the current dot product.
    always_comb begin
        case (r_col)
            2'd0: begin
                c_b[0] = r_l[0][0]; c_b[1] = r_l[1][0]; c_b[2] = r_l[2][0];
            end
            2'd1: begin
                c_b[0] = r_l[0][1]; c_b[1] = r_l[1][1]; c_b[2] = r_l[2][1];
            end
            2'd2: begin
                c_b[0] = r_l[0][2]; c_b[1] = r_l[1][2]; c_b[2] = r_l[2][2];
            end
            default: begin
                c_b[0] = r_lp0; c_b[1] = r_lp1; c_b[2] = '0;
            end
        endcase
    end

    assign c_sum = r_prod[0] + r_prod[1] + r_prod[2];
    assign c_rnd = round_q30(c_sum);

    always_comb begin
        logic signed [31:0] p [0:2];
        for (int i = 0; i < 3; i++) begin
            if (r_tp[i] > POS_MAX) begin
                p[i] = POS_MAX;
            end else if (r_tp[i] < -POS_MAX) begin
                p[i] = -POS_MAX;
            end else begin
                p[i] = r_tp[i];
            end
        end
        c_out = {7'd0,
                 r_t[2][2], r_t[2][1], r_t[2][0],
                 r_t[1][2], r_t[1][1], r_t[1][0],
                 r_t[0][2], r_t[0][1], r_t[0][0],
                 p[2][POS_W-1:0], p[1][POS_W-1:0], p[0][POS_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_m     <= LNK_UPPER;
            r_row   <= '0;
            r_col   <= '0;
            r_pvld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_pvld <= (r_state == ST_RUN);
            if (w_load) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_m     <= LNK_UPPER;
                        r_state <= ST_LP;
                    end
                end
                ST_LP: r_state <= ST_LP2;
                ST_LP2: begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (r_col == COL_POS) begin
                        r_col <= '0;
                        r_row <= r_row + 2'd1;
                        if (r_row == 2'd2) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                ST_DRAIN: r_state <= ST_COPY;
                ST_COPY: begin
                    if (r_m == LNK_LAST) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_m     <= r_m + 3'd1;
                        r_state <= ST_LP;
                    end
                end
                ST_OUT: if (w_load) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                for (int j = 0; j < NJ; j++) begin
                    r_s[j] <= i_trig.sn[j];
                    r_c[j] <= i_trig.cs[j];
                end
                // Base link is loaded directly as the running transform.
                r_t[0][0] <= i_trig.cs[0];  r_t[0][1] <= '0;  r_t[0][2] <= -i_trig.sn[0];
                r_t[1][0] <= i_trig.sn[0];  r_t[1][1] <= '0;  r_t[1][2] <= i_trig.cs[0];
                r_t[2][0] <= '0;  r_t[2][1] <= -ONE_Q30;  r_t[2][2] <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_tp[i] <= '0;
                end
            end
            ST_LP: begin
                r_l   <= c_l;
                r_lpc <= c_lc;
                r_lps <= c_ls;
            end
            ST_LP2: begin
                r_lp0 <= 32'(round_q30(r_lpc));
                r_lp1 <= 32'(round_q30(r_lps));
            end
            ST_COPY: begin
                r_t  <= r_nr;
                r_tp <= r_np;
            end
            default: begin
            end
        endcase

        r_prow <= r_row;
        r_pcol <= r_col;
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= r_t[r_row][k] * c_b[k];
        end

        if (r_pvld) begin
            if (r_pcol == COL_POS) begin
                r_np[r_prow] <= 32'(c_rnd) + r_tp[r_prow];
            end else begin
                r_nr[r_prow][r_pcol] <= clamp_q30(c_rnd);
            end
        end

        if (w_load) begin
            r_o_data <= c_out;
        end
    end

    `FK_ASSERT(a_stage2_from_run, r_pvld |-> $past(r_state == ST_RUN), "dot-product write without issue")
    `FK_ASSERT(a_copy_after_drain, (r_state == ST_COPY) |-> !r_pvld, "link copied before last write")
    `FK_ASSERT(a_last_link_out, (r_state == ST_COPY && r_m == LNK_LAST) |=> (r_state == ST_OUT), "pose not sent after last link")

endmodule

// ----- hw/rtl/arm_forward_kinematics_6dof.sv -----
// Top level of the six-joint arm forward kinematics.
// Instantiates fk_front, fk_queue and fk_back; depends on fk_pkg.
`timescale 1ns / 1ps

// Takes six joint angles (degrees, signed Q10.16) per input transfer and returns one
// pose per transfer: end-effector position (mm, Q11.16, saturated) and the 3x3
// rotation matrix (Q2.30). The front end computes all six sines and cosines in
// parallel lanes, and the back end chains the link transforms one after another
// through a single three-multiplier dot-product stage; that back end sets the
// sustained pose rate. A two-entry queue sits between the two ends, and an input
// holding register and the output register let a new item be taken while a finished
// pose waits. Link lengths are written through the configuration port (index 0 upper
// arm, index 1 forearm); the user must write them only while the block is idle,
// which the block itself does not enforce. Values above 65536000 are clamped.
module arm_forward_kinematics_6dof import fk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // joint1_angle..joint6_angle, 26 bits each from the lowest bit up
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // pos_x, pos_y, pos_z (27 bits each), then rot_00..rot_22 (32 bits each), lowest first
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [LEN_W-1:0]      i_cfg_data
);

    logic [LEN_W-1:0] r_upper_len;
    logic [LEN_W-1:0] r_fore_len;
    logic [LEN_W-1:0] w_cfg_val;

    logic  w_push, w_full, w_pop, w_empty;
    t_trig w_trig_in, w_trig_out;

    assign w_cfg_val = (i_cfg_data > LEN_MAX) ? LEN_MAX : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_len <= UPPER_RESET;
            r_fore_len  <= FORE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UPPER: r_upper_len <= w_cfg_val;
                CFG_FORE:  r_fore_len  <= w_cfg_val;
                default: begin
                end
            endcase
        end
    end

    fk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_angles (i_s_tdata[NJ*ANG_W-1:0]),
        .o_push   (w_push),
        .o_trig   (w_trig_in),
        .i_full   (w_full)
    );

    fk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_trig_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_trig_out),
        .o_empty (w_empty)
    );

    fk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_trig      (w_trig_out),
        .o_pop       (w_pop),
        .i_upper_len (r_upper_len),
        .i_fore_len  (r_fore_len),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata)
    );

endmodule
